// ----- rtl/upbd_pkg.sv -----
`default_nettype none

package upbd_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_BIND   = 2'd0,
        OP_UNBIND = 2'd1,
        OP_RECV   = 2'd2
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOHANDLER = 3'd2,
        ST_NOTBOUND  = 3'd3,
        ST_MALFORMED = 3'd4
    } t_status;

    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

    // One accepted input word, unpacked
    typedef struct packed {
        t_op         operation;
        logic [15:0] port;
        logic        handler_present;
        logic [7:0]  handler;
        logic [31:0] src_address;
        logic [15:0] src_port_in;
        logic [15:0] dest_port;
        logic [15:0] udp_length;
        logic [15:0] received_length;
    } t_item;

    // One result word, unpacked
    typedef struct packed {
        t_status     status;
        logic        deliver;
        logic [7:0]  handler_out;
        logic [31:0] src_address_out;
        logic [15:0] src_port_out;
        logic [15:0] payload_length;
    } t_result;

    // Update request from the decision logic to the binding table
    typedef struct packed {
        logic        do_bind;
        logic        do_unbind;
        logic [15:0] bind_port;
        logic [7:0]  bind_handler;
    } t_tbl_cmd;

    // Lookup answer from the binding table
    typedef struct packed {
        logic       hit;
        logic [7:0] hit_handler;
        logic       full;
    } t_tbl_rsp;

endpackage

`default_nettype wire

// ----- rtl/upbd_table.sv -----
`default_nettype none

module upbd_table
    import upbd_pkg::*;
#(
    parameter int PORT_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_key,
    input  wire t_tbl_cmd    i_cmd,
    output t_tbl_rsp         o_rsp
);

    logic [PORT_SLOTS-1:0] r_used;
    logic [15:0]           r_port    [PORT_SLOTS];
    logic [7:0]            r_handler [PORT_SLOTS];

    logic [PORT_SLOTS-1:0] match;
    logic [PORT_SLOTS-1:0] match_oh;
    logic [PORT_SLOTS-1:0] free_oh;
    logic [PORT_SLOTS-1:0] n_used;
    logic [7:0]            hit_handler;

    // Parallel compare of the key against every used slot
    always_comb begin
        for (int i = 0; i < PORT_SLOTS; i++) begin
            match[i] = r_used[i] && (r_port[i] == i_key);
        end
    end

    // Lowest set bit wins: first matching slot, first free slot
    assign match_oh = match & (~match + PORT_SLOTS'(1));
    assign free_oh  = ~r_used & (r_used + PORT_SLOTS'(1));

    // AND-OR select of the first match's handler
    always_comb begin
        hit_handler = '0;
        for (int i = 0; i < PORT_SLOTS; i++) begin
            hit_handler = hit_handler | (r_handler[i] & {8{match_oh[i]}});
        end
    end

    assign o_rsp.hit         = |match;
    assign o_rsp.hit_handler = hit_handler;
    assign o_rsp.full        = &r_used;

    // Next occupancy
    always_comb begin
        n_used = r_used;
        if (i_cmd.do_bind) begin
            n_used = r_used | free_oh;
        end else if (i_cmd.do_unbind) begin
            n_used = r_used & ~match_oh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    // Slot payload, written only when a bind claims the slot
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PORT_SLOTS; i++) begin
            if (i_cmd.do_bind && free_oh[i]) begin
                r_port[i]    <= i_cmd.bind_port;
                r_handler[i] <= i_cmd.bind_handler;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Occupancy only moves on a table command
    a_used_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.do_bind && !i_cmd.do_unbind) |=> $stable(r_used))
        else $error("slot occupancy changed without a command");

    // A bind into a non-full table claims exactly one slot
    a_bind_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_bind && !(&r_used))
        |=> $countones(r_used) == $past($countones(r_used)) + 1)
        else $error("bind did not claim exactly one slot");

    // An unbind that hits frees exactly one slot
    a_unbind_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.do_unbind && !i_cmd.do_bind && (|match))
        |=> $countones(r_used) + 1 == $past($countones(r_used)))
        else $error("unbind did not free exactly one slot");
`endif

endmodule

`default_nettype wire

// ----- rtl/upbd_exec.sv -----
`default_nettype none

module upbd_exec
    import upbd_pkg::*;
(
    input  wire logic     i_fire,
    input  wire t_item    i_item,
    input  wire t_tbl_rsp i_rsp,
    output logic [15:0]   o_key,
    output t_tbl_cmd      o_cmd,
    output t_result       o_res
);

    logic malformed;

    // Unbind looks up its own port, a receive its destination port
    assign o_key = (i_item.operation == OP_UNBIND) ? i_item.port : i_item.dest_port;

    assign malformed = (i_item.received_length < UDP_HDR_BYTES) ||
                       (i_item.udp_length > i_item.received_length) ||
                       (i_item.udp_length < UDP_HDR_BYTES);

    // Decide status, delivery and table update
    always_comb begin
        o_res              = '0;
        o_res.status       = ST_DONE;
        o_cmd              = '0;
        o_cmd.bind_port    = i_item.port;
        o_cmd.bind_handler = i_item.handler;
        case (i_item.operation)
            OP_BIND: begin
                if (!i_item.handler_present) begin
                    o_res.status = ST_NOHANDLER;
                end else if (i_rsp.full) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_cmd.do_bind = i_fire;
                end
            end
            OP_UNBIND: begin
                if (i_rsp.hit) begin
                    o_cmd.do_unbind = i_fire;
                end else begin
                    o_res.status = ST_NOTBOUND;
                end
            end
            OP_RECV: begin
                if (malformed) begin
                    o_res.status = ST_MALFORMED;
                end else if (i_rsp.hit) begin
                    o_res.deliver         = 1'b1;
                    o_res.handler_out     = i_rsp.hit_handler;
                    o_res.src_address_out = i_item.src_address;
                    o_res.src_port_out    = i_item.src_port_in;
                    o_res.payload_length  = i_item.udp_length - UDP_HDR_BYTES;
                end else begin
                    o_res.status = ST_NOTBOUND;
                end
            end
            default: begin
                // unknown kind: no effect, all-zero result
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/udp_port_binding_demux.sv -----
// UDP port binding table with receive demultiplexer.
// Slave channel (i_s_*): one command word per handshake. tuser selects bind,
// unbind or receive; tdata carries the port, handler and parsed UDP header
// fields. Master channel (o_m_*): exactly one result word per command word,
// in order, giving status and, for a delivered packet, the handler id,
// source address, source port and payload length.
// Each word passes two register stages, the input register and then the
// result register, whose contents drive o_m_*.
// Throughput: one word per cycle while the receiver does not stall; the
// table compare over all PORT_SLOTS entries and its update complete between
// the two registers, so the next word sees the updated table.
// Reset (synchronous, active low) empties the table and both stages.
// When the receiver stalls, the result register holds; one more word is
// taken into the input register, after which o_s_tready drops until the
// result is taken.
`default_nettype none

module udp_port_binding_demux
    import upbd_pkg::*;
#(
    parameter int PORT_SLOTS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata: port[15:0], handler_present[16], handler[24:17], src_address[56:25],
    //        src_port_in[72:57], dest_port[88:73], udp_length[104:89],
    //        received_length[120:105], zero fill [127:121]
    input  wire logic [127:0] i_s_tdata,
    // tuser: operation[1:0]
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tdata: status[2:0], deliver[3], handler_out[11:4], src_address_out[43:12],
    //        src_port_out[59:44], payload_length[75:60], zero fill [79:76]
    output logic [79:0]       o_m_tdata
);

    logic     r_in_valid;
    logic     n_in_valid;
    t_item    r_item;
    logic     r_out_valid;
    logic     n_out_valid;
    t_result  r_res;
    logic     fire;
    logic     s_acc;
    t_item    in_item;
    t_result  res;
    t_tbl_cmd cmd;
    t_tbl_rsp rsp;
    logic [15:0] key;

    // Stage handshake
    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;
    assign s_acc      = i_s_tvalid && o_s_tready;

    // Unpack the slave word
    always_comb begin
        in_item.operation       = t_op'(i_s_tuser);
        in_item.port            = i_s_tdata[15:0];
        in_item.handler_present = i_s_tdata[16];
        in_item.handler         = i_s_tdata[24:17];
        in_item.src_address     = i_s_tdata[56:25];
        in_item.src_port_in     = i_s_tdata[72:57];
        in_item.dest_port       = i_s_tdata[88:73];
        in_item.udp_length      = i_s_tdata[104:89];
        in_item.received_length = i_s_tdata[120:105];
    end

    // Valid flags of both stages
    always_comb begin
        n_in_valid = r_in_valid;
        if (s_acc) begin
            n_in_valid = 1'b1;
        end else if (fire) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_item <= in_item;
        end
        if (fire) begin
            r_res <= res;
        end
    end

    upbd_exec u_exec (
        .i_fire (fire),
        .i_item (r_item),
        .i_rsp  (rsp),
        .o_key  (key),
        .o_cmd  (cmd),
        .o_res  (res)
    );

    upbd_table #(
        .PORT_SLOTS (PORT_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key),
        .i_cmd   (cmd),
        .o_rsp   (rsp)
    );

    // Pack the master word
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_res.payload_length, r_res.src_port_out,
                         r_res.src_address_out, r_res.handler_out, r_res.deliver,
                         r_res.status};

endmodule

`default_nettype wire
